// File: sv/fhss_pkg.sv
// shared types and constants for the hop-slot clock
package fhss_pkg;

   localparam int TIME_W   = 32;
   localparam int SLOT_W   = 32;
   localparam int LEN_W    = 16;
   localparam int AIR_W    = 24;
   localparam int OFFS_W   = 8;
   localparam int CMD_W    = 2;
   localparam int STEP_W   = 5;

   localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ANCHOR    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ANCHOR_RX = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd3;

   localparam logic [LEN_W-1:0] SLOT_LEN_RESET = 16'd100;

   // microseconds to milliseconds, rounded half-up, by reciprocal multiply:
   // q = (x * ceil(2^35 / 1000)) >> 35 is exact for x < 2^25
   localparam int                US_SUM_W    = AIR_W + 1;
   localparam logic [US_SUM_W-1:0] US_HALF   = 25'd500;
   localparam int                RCP_W       = 26;
   localparam logic [RCP_W-1:0]  US_RCP      = 26'd34359739;
   localparam int                RCP_SHIFT   = 35;
   localparam int                PROD_W      = US_SUM_W + RCP_W;
   localparam int                AIR_MS_W    = 15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_DIV,
      ST_FIN
   } fhss_state_type;

   typedef struct packed {
      logic latch;
      logic mul;
      logic update;
      logic div_step;
      logic finish;
   } fhss_ctl_type;

   typedef struct packed {
      logic rsp_full;
   } fhss_sts_type;

endpackage

// File: sv/fhss_ctrl.sv
// sequencer for the hop-slot clock: item intake, divide steps and result hand-off
module fhss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fhss_pkg::fhss_sts_type sts,
   output fhss_pkg::fhss_ctl_type ctl
);
   import fhss_pkg::*;

   fhss_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            ctl.update = 1'b1;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait until the output register is free
            if (!sts.rsp_full) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_latch_then_mul: assert property (@(posedge clock) disable iff (reset)
      ctl.latch |=> ctl.mul)
      else $error("multiply did not follow item intake");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (ctl.div_step && step_ff == '1) |=> (state_ff == ST_FIN))
      else $error("divide did not end after last step");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> !sts.rsp_full)
      else $error("result written while output register held");

   a_update_then_div: assert property (@(posedge clock) disable iff (reset)
      ctl.update |=> (ctl.div_step && step_ff == '0))
      else $error("divide did not start at step zero");

endmodule

// File: sv/fhss_dp.sv
// anchor state, airtime conversion, restoring divider and output register
module fhss_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fhss_pkg::CMD_W-1:0]    req_cmd,
   input  logic [fhss_pkg::TIME_W-1:0]   req_time_ms,
   input  logic [fhss_pkg::SLOT_W-1:0]   req_new_slot,
   input  logic [fhss_pkg::AIR_W-1:0]    req_airtime_us,
   input  logic [fhss_pkg::OFFS_W-1:0]   req_slot_offset_ms,
   input  logic                          csr_valid,
   input  logic [fhss_pkg::LEN_W-1:0]    csr_slot_length_ms,
   input  fhss_pkg::fhss_ctl_type        ctl,
   output fhss_pkg::fhss_sts_type        sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_anchored,
   output logic [fhss_pkg::SLOT_W-1:0]   rsp_current_slot,
   output logic [fhss_pkg::LEN_W-1:0]    rsp_ms_into_slot,
   output logic [fhss_pkg::TIME_W-1:0]   rsp_anchor_age_ms
);
   import fhss_pkg::*;

   logic [LEN_W-1:0]    slot_len_ff;
   logic [TIME_W-1:0]   anchor_time_ff, anchor_time_in;
   logic [SLOT_W-1:0]   anchor_slot_ff, anchor_slot_in;
   logic                anchored_ff, anchored_in;

   logic [CMD_W-1:0]    cmd_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [AIR_W-1:0]    air_ff;
   logic [OFFS_W-1:0]   offs_ff;
   logic [AIR_MS_W-1:0] air_ms_ff;

   logic [TIME_W-1:0]   elapsed_ff;
   logic [TIME_W-1:0]   quo_ff;
   logic [LEN_W-1:0]    rem_ff;
   logic [LEN_W-1:0]    div_len_ff;

   logic                rsp_valid_ff;
   logic                rsp_anchored_ff;
   logic [SLOT_W-1:0]   rsp_current_slot_ff;
   logic [LEN_W-1:0]    rsp_ms_into_slot_ff;
   logic [TIME_W-1:0]   rsp_anchor_age_ms_ff;

   logic [US_SUM_W-1:0] air_sum;
   logic [PROD_W-1:0]   air_prod;
   logic [TIME_W-1:0]   rx_time;
   logic [TIME_W-1:0]   elapsed_in;
   logic [LEN_W-1:0]    eff_len;
   logic [LEN_W:0]      rem_sh;
   logic                rem_ge;
   logic [LEN_W:0]      rem_sub;

   assign air_sum  = US_SUM_W'(air_ff) + US_HALF;
   assign air_prod = PROD_W'(air_sum) * PROD_W'(US_RCP);
   assign rx_time  = time_ff - TIME_W'(air_ms_ff) - TIME_W'(offs_ff);
   assign eff_len  = (slot_len_ff == '0) ? LEN_W'(1) : slot_len_ff;

   always_comb begin
      anchor_time_in = anchor_time_ff;
      anchor_slot_in = anchor_slot_ff;
      anchored_in    = anchored_ff;
      case (cmd_ff)
         CMD_ANCHOR: begin
            anchor_time_in = time_ff;
            anchor_slot_in = slot_ff;
            anchored_in    = 1'b1;
         end
         CMD_ANCHOR_RX: begin
            anchor_time_in = rx_time;
            anchor_slot_in = slot_ff;
            anchored_in    = 1'b1;
         end
         CMD_CLEAR: begin
            anchor_time_in = '0;
            anchor_slot_in = '0;
            anchored_in    = 1'b0;
         end
         default: begin
            anchored_in = anchored_ff;
         end
      endcase
   end

   assign elapsed_in = time_ff - anchor_time_in;

   // one restoring step: remainder stays below the divisor
   assign rem_sh  = {rem_ff, quo_ff[TIME_W-1]};
   assign rem_ge  = rem_sh >= {1'b0, div_len_ff};
   assign rem_sub = rem_sh - {1'b0, div_len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_len_ff    <= SLOT_LEN_RESET;
         anchor_time_ff <= '0;
         anchor_slot_ff <= '0;
         anchored_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            slot_len_ff <= csr_slot_length_ms;
         end
         if (ctl.update) begin
            anchor_time_ff <= anchor_time_in;
            anchor_slot_ff <= anchor_slot_in;
            anchored_ff    <= anchored_in;
         end
         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff  <= req_cmd;
         time_ff <= req_time_ms;
         slot_ff <= req_new_slot;
         air_ff  <= req_airtime_us;
         offs_ff <= req_slot_offset_ms;
      end
      if (ctl.mul) begin
         air_ms_ff <= air_prod[RCP_SHIFT +: AIR_MS_W];
      end
      if (ctl.update) begin
         elapsed_ff <= elapsed_in;
         quo_ff     <= elapsed_in;
         rem_ff     <= '0;
         div_len_ff <= eff_len;
      end else if (ctl.div_step) begin
         quo_ff <= {quo_ff[TIME_W-2:0], rem_ge};
         rem_ff <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      end
      if (ctl.finish) begin
         rsp_anchored_ff      <= anchored_ff;
         rsp_current_slot_ff  <= anchor_slot_ff + quo_ff;
         rsp_ms_into_slot_ff  <= rem_ff;
         rsp_anchor_age_ms_ff <= elapsed_ff;
      end
   end

   assign sts.rsp_full      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_anchored      = rsp_anchored_ff;
   assign rsp_current_slot  = rsp_current_slot_ff;
   assign rsp_ms_into_slot  = rsp_ms_into_slot_ff;
   assign rsp_anchor_age_ms = rsp_anchor_age_ms_ff;

endmodule

// File: sv/fhss_slot_clock_core.sv
// top level of the hop-slot clock: sequencer plus datapath
// Each item (query, anchor, anchor from received frame, clear) returns one
// result after it is accepted, in these steps: the airtime reciprocal
// multiply, the anchor update, the bit-serial restoring divide by the slot
// length, and the load of the output register, which waits while that
// register is still full. The next item can be accepted in the cycle after
// the load. One item is worked on at a time; a new item may be accepted
// while the previous result still waits in the output register. A slot
// length of zero acts as one. The slot length register may be written only
// while idle.
module fhss_slot_clock_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fhss_pkg::CMD_W-1:0]    req_cmd,
   input  logic [fhss_pkg::TIME_W-1:0]   req_time_ms,
   input  logic [fhss_pkg::SLOT_W-1:0]   req_new_slot,
   input  logic [fhss_pkg::AIR_W-1:0]    req_airtime_us,
   input  logic [fhss_pkg::OFFS_W-1:0]   req_slot_offset_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_anchored,
   output logic [fhss_pkg::SLOT_W-1:0]   rsp_current_slot,
   output logic [fhss_pkg::LEN_W-1:0]    rsp_ms_into_slot,
   output logic [fhss_pkg::TIME_W-1:0]   rsp_anchor_age_ms,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fhss_pkg::LEN_W-1:0]    csr_slot_length_ms
);
   import fhss_pkg::*;

   fhss_ctl_type ctl;
   fhss_sts_type sts;

   assign csr_ready = 1'b1;

   fhss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   fhss_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_time_ms        (req_time_ms),
      .req_new_slot       (req_new_slot),
      .req_airtime_us     (req_airtime_us),
      .req_slot_offset_ms (req_slot_offset_ms),
      .csr_valid          (csr_valid),
      .csr_slot_length_ms (csr_slot_length_ms),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_anchored       (rsp_anchored),
      .rsp_current_slot   (rsp_current_slot),
      .rsp_ms_into_slot   (rsp_ms_into_slot),
      .rsp_anchor_age_ms  (rsp_anchor_age_ms)
   );

endmodule

// File: sim/fhss_slot_clock_checker.sv
// checker for the hop-slot clock: follows the channels, predicts each result and compares it
module fhss_slot_clock_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [fhss_pkg::CMD_W-1:0]  req_cmd,
   input  logic [fhss_pkg::TIME_W-1:0] req_time_ms,
   input  logic [fhss_pkg::SLOT_W-1:0] req_new_slot,
   input  logic [fhss_pkg::AIR_W-1:0]  req_airtime_us,
   input  logic [fhss_pkg::OFFS_W-1:0] req_slot_offset_ms,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_anchored,
   input  logic [fhss_pkg::SLOT_W-1:0] rsp_current_slot,
   input  logic [fhss_pkg::LEN_W-1:0]  rsp_ms_into_slot,
   input  logic [fhss_pkg::TIME_W-1:0] rsp_anchor_age_ms,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [fhss_pkg::LEN_W-1:0]  csr_slot_length_ms,
   output int                          fail_count,
   output int                          pending,
   output int                          checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fhss_pkg::*;

   localparam logic [31:0] ROUND_HALF_US = 32'd500;
   localparam logic [31:0] US_PER_MS     = 32'd1000;

   typedef struct packed {
      logic              anchored;
      logic [SLOT_W-1:0] current_slot;
      logic [LEN_W-1:0]  ms_into_slot;
      logic [TIME_W-1:0] anchor_age_ms;
   } slot_time_type;

   logic [TIME_W-1:0] anchor_time;
   logic [SLOT_W-1:0] anchor_slot;
   logic              anchored;
   logic [LEN_W-1:0]  slot_len;
   slot_time_type     slot_times_due[$];
   int                fails = 0;
   int                checks = 0;

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
   end

   // applies one command to the anchor and returns the clock reading at its time
   function automatic slot_time_type advance_slot_clock(input logic [CMD_W-1:0] cmd,
                                                        input logic [TIME_W-1:0] t,
                                                        input logic [SLOT_W-1:0] slot,
                                                        input logic [AIR_W-1:0] air_us,
                                                        input logic [OFFS_W-1:0] offs);
      logic [31:0]   divisor;
      logic [31:0]   air_ms;
      logic [31:0]   elapsed;
      slot_time_type r;
      divisor = (slot_len == '0) ? 32'd1 : {16'd0, slot_len};
      case (cmd)
         CMD_ANCHOR: begin
            anchor_time = t;
            anchor_slot = slot;
            anchored    = 1'b1;
         end
         CMD_ANCHOR_RX: begin
            air_ms      = ({8'd0, air_us} + ROUND_HALF_US) / US_PER_MS;
            anchor_time = t - air_ms - {24'd0, offs};
            anchor_slot = slot;
            anchored    = 1'b1;
         end
         CMD_CLEAR: begin
            anchor_time = '0;
            anchor_slot = '0;
            anchored    = 1'b0;
         end
         default: ;
      endcase
      elapsed         = t - anchor_time;
      r.anchored      = anchored;
      r.current_slot  = anchor_slot + elapsed / divisor;
      r.ms_into_slot  = 16'(elapsed % divisor);
      r.anchor_age_ms = elapsed;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      slot_time_type due;
      if (reset) begin
         slot_len    = SLOT_LEN_RESET;
         anchor_time = '0;
         anchor_slot = '0;
         anchored    = 1'b0;
         slot_times_due.delete();
      end else begin
         // results first, so a stray one is never hidden by a fresh item
         if (rsp_valid && rsp_ready) begin
            if (slot_times_due.size() == 0) begin
               $error("result item with no item pending");
               fails++;
            end else begin
               due = slot_times_due.pop_front();
               compare_field("anchored", due.anchored, rsp_anchored);
               compare_field("current_slot", due.current_slot, rsp_current_slot);
               compare_field("ms_into_slot", due.ms_into_slot, rsp_ms_into_slot);
               compare_field("anchor_age_ms", due.anchor_age_ms, rsp_anchor_age_ms);
               checks++;
            end
         end
         if (csr_valid && csr_ready)
            slot_len = csr_slot_length_ms;
         if (req_valid && req_ready)
            slot_times_due.push_back(advance_slot_clock(req_cmd, req_time_ms, req_new_slot,
                                                        req_airtime_us, req_slot_offset_ms));
      end
      fail_count    <= fails;
      pending       <= slot_times_due.size();
      checked_count <= checks;
   end

endmodule

// File: sim/tb_top.sv
// testbench top for the hop-slot clock: stimulus, flow control and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fhss_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 205;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd = CMD_QUERY;
   logic [TIME_W-1:0] req_time_ms = '0;
   logic [SLOT_W-1:0] req_new_slot = '0;
   logic [AIR_W-1:0]  req_airtime_us = '0;
   logic [OFFS_W-1:0] req_slot_offset_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_anchored;
   logic [SLOT_W-1:0] rsp_current_slot;
   logic [LEN_W-1:0]  rsp_ms_into_slot;
   logic [TIME_W-1:0] rsp_anchor_age_ms;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_slot_length_ms = '0;
   int                fail_count;
   int                pending;
   int                checked_count;

   int                cycle_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   int                stall_left = 0;
   logic [TIME_W-1:0] now_ms = '0;
   logic [LEN_W-1:0]  slot_len_now = SLOT_LEN_RESET;
   logic [LEN_W-1:0]  phase_len[PHASES];
   int                phase_sender_pct[PHASES]   = '{0, 58, 0, 33, 0, 58, 0, 33};
   int                phase_receiver_pct[PHASES] = '{0, 0, 58, 33, 0, 0, 58, 33};

   fhss_slot_clock_core i_dut (.*);

   fhss_slot_clock_checker i_checker (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: short stalls mostly, now and then one long enough to back up the block
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(99) < receiver_stall_pct) begin
         stall_left <= ($urandom_range(3) == 0) ? $urandom_range(8, 60) : 0;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                            input logic [SLOT_W-1:0] slot, input logic [AIR_W-1:0] air_us,
                            input logic [OFFS_W-1:0] offs);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(3) == 0) ? $urandom_range(5, 45) : $urandom_range(1, 2))
            @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_time_ms        <= t;
      req_new_slot       <= slot;
      req_airtime_us     <= air_us;
      req_slot_offset_ms <= offs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_slot_length(input logic [LEN_W-1:0] len);
      drain();
      repeat (4) @(posedge clock);
      csr_valid          <= 1'b1;
      csr_slot_length_ms <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      slot_len_now = len;
   endtask

   // mostly queries around the last anchor, with anchors, received-frame anchors, jumps and clears mixed in
   task automatic send_random_item();
      logic [CMD_W-1:0]  cmd;
      logic [TIME_W-1:0] t;
      logic [SLOT_W-1:0] slot;
      logic [AIR_W-1:0]  air_us;
      logic [OFFS_W-1:0] offs;
      int                span;
      int                pick;
      span = (slot_len_now == '0) ? 4 : 3 * int'(slot_len_now) + 2;
      if ($urandom_range(99) < 4)
         now_ms = $urandom;
      else
         now_ms += $urandom_range(0, span);
      slot   = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
      air_us = ($urandom_range(3) == 0) ? AIR_W'($urandom) : AIR_W'($urandom_range(0, 200000));
      offs   = OFFS_W'($urandom);
      t      = now_ms;
      pick   = $urandom_range(99);
      if (pick < 12) begin
         cmd = CMD_ANCHOR;
         t   = now_ms - $urandom_range(0, span);
      end else if (pick < 27) begin
         cmd = CMD_ANCHOR_RX;
      end else if (pick < 32) begin
         cmd = CMD_CLEAR;
      end else begin
         cmd = CMD_QUERY;
      end
      send_item(cmd, t, slot, air_us, offs);
   endtask

   initial begin
      foreach (phase_len[i]) phase_len[i] = LEN_W'($urandom_range(2, 65534));
      phase_len[0] = 16'd1;
      phase_len[1] = 16'hFFFF;
      phase_len[2] = 16'd0;
      phase_len[3] = 16'd7;
      phase_len[5] = 16'd1000;
      phase_len[7] = SLOT_LEN_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset slot length
      send_item(CMD_QUERY,     32'd0,         32'd0,         24'd0,        8'd0);
      send_item(CMD_QUERY,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF,  8'hFF);
      send_item(CMD_ANCHOR,    32'd1000,      32'd5,         24'hFF_FFFF,  8'hFF);
      send_item(CMD_QUERY,     32'd1250,      32'd0,         24'd0,        8'd0);
      send_item(CMD_QUERY,     32'd999,       32'hFFFF_FFFF, 24'hFF_FFFF,  8'hFF);
      send_item(CMD_ANCHOR,    32'hFFFF_FFF0, 32'hFFFF_FFFF, 24'd0,        8'd0);
      send_item(CMD_QUERY,     32'h0000_0100, 32'd0,         24'd0,        8'd0);
      send_item(CMD_ANCHOR_RX, 32'd50,        32'd7,         24'd0,        8'hFF);
      send_item(CMD_QUERY,     32'd300,       32'd0,         24'd0,        8'd0);
      send_item(CMD_ANCHOR_RX, 32'd100000,    32'd1,         24'd499,      8'd0);
      send_item(CMD_ANCHOR_RX, 32'd100000,    32'd1,         24'd500,      8'd0);
      send_item(CMD_ANCHOR_RX, 32'd100000,    32'd2,         24'd1499,     8'd0);
      send_item(CMD_ANCHOR_RX, 32'd100000,    32'd2,         24'd1500,     8'd0);
      send_item(CMD_ANCHOR_RX, 32'hFFFF_FFFF, 32'd0,         24'hFF_FFFF,  8'hFF);
      send_item(CMD_QUERY,     32'hFFFF_FFFF, 32'd0,         24'd0,        8'd0);
      send_item(CMD_CLEAR,     32'd12345,     32'hA5A5_5A5A, 24'h5A_A5A5,  8'hA5);
      send_item(CMD_QUERY,     32'd12399,     32'd0,         24'd0,        8'd0);
      send_item(CMD_CLEAR,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF,  8'hFF);
      send_item(CMD_ANCHOR_RX, 32'd0,         32'd0,         24'hFF_FFFF,  8'hFF);
      send_item(CMD_QUERY,     32'd0,         32'd0,         24'd0,        8'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_slot_length(phase_len[phase]);
         sender_idle_pct    = phase_sender_pct[phase];
         receiver_stall_pct = phase_receiver_pct[phase];
         repeat (PHASE_ITEMS) send_random_item();
      end

      drain();
      repeat (40) @(posedge clock);
      $display("checked %0d result items over %0d slot lengths, zero, one and full scale",
               checked_count, PHASES + 1);
      $display("anchors, received-frame anchors, clears and queries, with and without stalls");
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
